// File: hw/rtl/ccmf_pkg.sv
// Shared constants, codes and types for the cylinder cut momentum filter.
`timescale 1ns / 1ps

package ccmf_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int COMP_W     = 19;
  localparam int ABS_W      = COMP_W;
  localparam int SQ_W       = 2 * ABS_W - 1;
  localparam int SQSUM_W    = SQ_W + 2;
  localparam int ASUM_W     = ABS_W + 2;
  localparam int LHS_W      = SQSUM_W + 2;
  localparam int DIMS_W     = 3;
  localparam int RAD_W      = 18;
  localparam int RSQ_W      = 2 * RAD_W;
  localparam int RHS_W      = RSQ_W + 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = RAD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DIMS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = CFG_IDX_W'(1);

  localparam logic [DIMS_W-1:0] DIMS_MAX = DIMS_W'(MAX_DIMS);
  localparam logic [DIMS_W-1:0] DIMS_MIN = DIMS_W'(1);
  localparam logic [DIMS_W-1:0] DIMS_RST = DIMS_W'(4);
  localparam logic [RAD_W-1:0]  RAD_RST  = RAD_W'(15729);
  localparam logic [RSQ_W-1:0]  RSQ_RST  = RSQ_W'(64'(RAD_RST) * 64'(RAD_RST));
  localparam logic [RHS_W-1:0]  RHS_RST  = RHS_W'(64'(DIMS_RST) * 64'(RSQ_RST));

  typedef logic [ABS_W-1:0] abs_t;
  typedef logic [SQ_W-1:0]  sq_t;

  typedef struct packed {
    logic [DIMS_W-1:0] n;
    logic [RHS_W-1:0]  rhs;
  } ccmf_cfg_t;

endpackage

// File: hw/rtl/ccmf_if.sv
// Channel interfaces: momentum request, cut result and register write.
`timescale 1ns / 1ps

interface ccmf_mom_if
  import ccmf_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] comp_0;
  logic signed [COMP_W-1:0] comp_1;
  logic signed [COMP_W-1:0] comp_2;
  logic signed [COMP_W-1:0] comp_3;
  modport source (output valid, comp_0, comp_1, comp_2, comp_3, input ready);
  modport sink (input valid, comp_0, comp_1, comp_2, comp_3, output ready);
endinterface

interface ccmf_res_if;
  logic valid;
  logic ready;
  logic passes_cut;
  modport source (output valid, passes_cut, input ready);
  modport sink (input valid, passes_cut, output ready);
endinterface

interface ccmf_cfg_if
  import ccmf_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/cylinder_cut_momentum_filter.sv
// An accepted momentum request passes the abs, squares, sums, distance-term and compare stages to its result.
// Throughput: one request per cycle; stalls back up stage by stage, bubbles are squeezed out.
// Register writes reach the n*w^2 term via active_dims then rhs, or cylinder_radius, rad_sq then rhs; masking at once.
// Reset (rst, synchronous): pipeline empties, active_dims = 4, radius = 15729.
`timescale 1ns / 1ps

module cylinder_cut_momentum_filter
  import ccmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ccmf_mom_if.sink   mom,
  ccmf_res_if.source res,
  ccmf_cfg_if.sink   cfg
);

  ccmf_cfg_t cfg_bus;

  ccmf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_out (cfg_bus)
  );

  ccmf_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .cfg_in (cfg_bus),
    .mom    (mom),
    .res    (res)
  );

endmodule

// File: hw/rtl/ccmf_cfg.sv
// Configuration registers and precomputed right-hand side n*w^2.
`timescale 1ns / 1ps

module ccmf_cfg
  import ccmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ccmf_cfg_if.sink   cfg,
  output ccmf_cfg_t  cfg_out
);

  logic [DIMS_W-1:0] active_dims;
  logic [RAD_W-1:0]  cylinder_radius;
  logic [RSQ_W-1:0]  rad_sq;
  logic [RHS_W-1:0]  rhs;
  logic [DIMS_W-1:0] n_clamp;

  assign cfg.ready = 1'b1;

  always_comb begin
    priority if (active_dims < DIMS_MIN) begin
      n_clamp = DIMS_MIN;
    end else if (active_dims > DIMS_MAX) begin
      n_clamp = DIMS_MAX;
    end else begin
      n_clamp = active_dims;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_dims     <= DIMS_RST;
      cylinder_radius <= RAD_RST;
      rad_sq          <= RSQ_RST;
      rhs             <= RHS_RST;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_ACTIVE_DIMS) begin
          active_dims <= cfg.data[DIMS_W-1:0];
        end else if (cfg.index == CFG_RADIUS) begin
          cylinder_radius <= cfg.data[RAD_W-1:0];
        end
      end
      rad_sq <= RSQ_W'(cylinder_radius) * RSQ_W'(cylinder_radius);
      rhs    <= RHS_W'(n_clamp) * RHS_W'(rad_sq);
    end
  end

  assign cfg_out.n   = n_clamp;
  assign cfg_out.rhs = rhs;

endmodule

// File: hw/rtl/ccmf_pipe.sv
// Five-stage pipeline: abs, squares, sums, distance term, compare.
`timescale 1ns / 1ps

module ccmf_pipe
  import ccmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ccmf_cfg_t  cfg_in,
  ccmf_mom_if.sink   mom,
  ccmf_res_if.source res
);

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  logic [DIMS_W-1:0]  n1, n2, n3;
  abs_t               abs1 [MAX_DIMS];
  sq_t                sq2 [MAX_DIMS];
  logic [ASUM_W-1:0]  asum2;
  logic [SQSUM_W-1:0] sqsum3;
  logic [LHS_W-1:0]   ssq3;
  logic [LHS_W-1:0]   lhs4;
  logic               pass5;

  logic signed [COMP_W-1:0] comp [MAX_DIMS];
  abs_t                     abs1_next [MAX_DIMS];

  always_comb begin
    en5 = !v5 || res.ready;
    en4 = !v4 || en5;
    en3 = !v3 || en4;
    en2 = !v2 || en3;
    en1 = !v1 || en2;
  end

  assign mom.ready = en1;

  assign comp[0] = mom.comp_0;
  assign comp[1] = mom.comp_1;
  assign comp[2] = mom.comp_2;
  assign comp[3] = mom.comp_3;

  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (DIMS_W'(k) < cfg_in.n) begin
        abs1_next[k] = comp[k][COMP_W-1] ? ABS_W'(~comp[k] + 1'b1) : ABS_W'(comp[k]);
      end else begin
        abs1_next[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= mom.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      n1 <= cfg_in.n;
      for (int k = 0; k < MAX_DIMS; k++) begin
        abs1[k] <= abs1_next[k];
      end
    end
    if (en2) begin
      n2 <= n1;
      for (int k = 0; k < MAX_DIMS; k++) begin
        sq2[k] <= SQ_W'(SQ_W'(abs1[k]) * SQ_W'(abs1[k]));
      end
      asum2 <= ASUM_W'(abs1[0]) + ASUM_W'(abs1[1]) + ASUM_W'(abs1[2]) + ASUM_W'(abs1[3]);
    end
    if (en3) begin
      n3     <= n2;
      sqsum3 <= SQSUM_W'(sq2[0]) + SQSUM_W'(sq2[1]) + SQSUM_W'(sq2[2]) + SQSUM_W'(sq2[3]);
      ssq3   <= LHS_W'(asum2) * LHS_W'(asum2);
    end
    if (en4) begin
      lhs4 <= LHS_W'(n3) * LHS_W'(sqsum3) - ssq3;
    end
    if (en5) begin
      pass5 <= (lhs4 <= LHS_W'(cfg_in.rhs));
    end
  end

  assign res.valid      = v5;
  assign res.passes_cut = pass5;

`ifndef SYNTHESIS
  a_n_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (n1 >= DIMS_MIN) && (n1 <= DIMS_MAX))
    else $error("dimension count out of range in stage 1");

  a_asum_bound: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (asum2 <= (ASUM_W'(n2) << (ABS_W - 1))))
    else $error("absolute sum exceeds active dimension bound");

  a_cauchy: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (LHS_W'(n3) * LHS_W'(sqsum3) >= ssq3))
    else $error("n*|q|^2 below s^2");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    v5 && !res.ready |=> v5 && $stable(pass5))
    else $error("stalled result lost or changed");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the cylinder cut momentum filter.
`timescale 1ns / 1ps

module testbench
  import ccmf_pkg::*;
();

  localparam int PIPE_LATENCY = 5;
  localparam int HOLD_CYCLES  = 60;
  localparam int MAG_MAX      = 2 ** (COMP_W - 1) - 1;

  localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W - 1){1'b1}}};
  localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W - 1){1'b0}}};
  localparam logic [RAD_W-1:0]         RAD_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_TOP = '1;

  typedef logic signed [COMP_W-1:0]          comp_t;
  typedef logic [MAX_DIMS-1:0][COMP_W-1:0]   mom_vec_t;

  logic clk = 1'b0;
  logic rst;

  ccmf_mom_if mom ();
  ccmf_res_if res ();
  ccmf_cfg_if cfg ();

  cylinder_cut_momentum_filter dut (
    .clk (clk),
    .rst (rst),
    .mom (mom),
    .res (res),
    .cfg (cfg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the block's registers
  logic [DIMS_W-1:0] cut_dims   = DIMS_RST;
  logic [RAD_W-1:0]  cut_radius = RAD_RST;

  bit expected_cut [$];
  bit want_cut;
  int mismatches   = 0;
  int results_seen = 0;
  bit src_idle     = 1'b1;
  bit snk_idle     = 1'b1;
  bit hold_sink    = 1'b0;

  // n*|q|^2 - s^2 <= n*w^2 with s the sum of magnitudes
  function automatic bit predict_cut(input mom_vec_t v);
    longint unsigned n, sq_sum, abs_sum, mag, lhs, rhs;
    longint          c;
    n = cut_dims;
    if (n < 1) n = 1;
    if (n > MAX_DIMS) n = MAX_DIMS;
    sq_sum  = 0;
    abs_sum = 0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (k < n) begin
        c = longint'($signed(v[k]));
        mag = (c < 0) ? longint'(-c) : longint'(c);
        sq_sum  += mag * mag;
        abs_sum += mag;
      end
    end
    lhs = n * sq_sum - abs_sum * abs_sum;
    rhs = n * (longint'(cut_radius) * longint'(cut_radius));
    return lhs <= rhs;
  endfunction

  function automatic mom_vec_t momentum(input comp_t c0, input comp_t c1,
                                        input comp_t c2, input comp_t c3);
    mom_vec_t v;
    v[0] = c0;
    v[1] = c1;
    v[2] = c2;
    v[3] = c3;
    return v;
  endfunction

  // half vectors close to a body diagonal, the rest small and raw-bit vectors
  function automatic mom_vec_t random_momentum();
    mom_vec_t    v;
    int          base, spread, mag;
    int unsigned pick;
    pick   = $urandom_range(0, 9);
    base   = int'($urandom_range(0, MAG_MAX) >> $urandom_range(0, 12));
    spread = int'(cut_radius) / 2 + 8;
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (pick < 5) begin
        mag = base + int'($urandom_range(0, 2 * spread)) - spread;
      end else begin
        mag = int'($urandom_range(0, cut_radius));
      end
      if (mag < 0) mag = -mag;
      if (mag > MAG_MAX) mag = MAG_MAX;
      v[k] = $urandom_range(0, 1) ? COMP_W'(-mag) : COMP_W'(mag);
      if (pick >= 8) v[k] = COMP_W'($urandom());
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("%0t: passes_cut mismatch on result %0d (%s): got %b, expected %b",
             $time, results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic send_momentum(input mom_vec_t v);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      mom.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mom.valid  <= 1'b1;
    mom.comp_0 <= v[0];
    mom.comp_1 <= v[1];
    mom.comp_2 <= v[2];
    mom.comp_3 <= v[3];
    do @(posedge clk); while (!mom.ready);
    expected_cut.push_back(predict_cut(v));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    if (idx == CFG_ACTIVE_DIMS) begin
      cut_dims = data[DIMS_W-1:0];
    end else if (idx == CFG_RADIUS) begin
      cut_radius = data[RAD_W-1:0];
    end
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    mom.valid <= 1'b0;
    while (expected_cut.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic test_reset_config();
    send_momentum(momentum(0, 0, 0, 0));
    send_momentum(momentum(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
    send_momentum(momentum(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
    send_momentum(momentum(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN));
    send_momentum(momentum(65536, 0, 0, 0));
    // just inside and just outside the default radius
    send_momentum(momentum(100000, -100000, 100000, -118162));
    send_momentum(momentum(100000, -100000, 100000, -118163));
    send_momentum(momentum(COMP_MAX, 0, COMP_MIN, 0));
  endtask

  task automatic test_unused_components();
    settle();
    write_reg(CFG_ACTIVE_DIMS, 2);
    write_reg(CFG_RADIUS, 1000);
    send_momentum(momentum(5000, -5000, COMP_MAX, COMP_MIN));
    send_momentum(momentum(5000, -6500, 0, 0));
    settle();
    write_reg(CFG_ACTIVE_DIMS, 3);
    send_momentum(momentum(COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX));
    send_momentum(momentum(COMP_MIN, COMP_MIN, 0, COMP_MIN));
  endtask

  task automatic test_dims_saturation();
    settle();
    write_reg(CFG_RADIUS, 0);
    // zero dims behaves as one; upper data bits are dropped
    write_reg(CFG_ACTIVE_DIMS, {{(CFG_DATA_W - DIMS_W){1'b1}}, DIMS_W'(0)});
    send_momentum(momentum(COMP_MAX, 0, COMP_MIN, 12345));
    settle();
    write_reg(CFG_ACTIVE_DIMS, 5);
    send_momentum(momentum(7, -7, 7, -7));
    send_momentum(momentum(7, -7, 7, -8));
    settle();
    write_reg(CFG_ACTIVE_DIMS, 7);
    send_momentum(momentum(-7, 7, -7, 7));
    send_momentum(momentum(7, -7, 7, -8));
  endtask

  task automatic test_ignored_index();
    settle();
    write_reg(CFG_UNMAPPED, '1);
    write_reg(CFG_UNMAPPED_TOP, '1);
    send_momentum(momentum(7, -7, 7, -8));
  endtask

  task automatic test_radius_extremes();
    settle();
    write_reg(CFG_ACTIVE_DIMS, 4);
    write_reg(CFG_RADIUS, RAD_MAX);
    send_momentum(momentum(COMP_MAX, 0, COMP_MIN, 0));
    send_momentum(momentum(COMP_MAX, 0, 0, 0));
  endtask

  task automatic random_phase(input logic [DIMS_W-1:0] dims, input logic [RAD_W-1:0] radius,
                              input int count, input bit s_idle, input bit k_idle);
    settle();
    write_reg(CFG_ACTIVE_DIMS, dims);
    write_reg(CFG_RADIUS, radius);
    src_idle = s_idle;
    snk_idle = k_idle;
    repeat (count) send_momentum(random_momentum());
  endtask

  task automatic test_random_sweep();
    random_phase(DIMS_RST, RAD_RST, 70, 1'b1, 1'b1);
    random_phase(1, $urandom_range(0, 40000), 70, 1'b1, 1'b1);
    random_phase(2, $urandom_range(0, 4000), 70, 1'b1, 1'b0);
    random_phase(3, $urandom_range(0, 40000), 70, 1'b0, 1'b1);
    random_phase(4, 0, 70, 1'b1, 1'b1);
    random_phase(4, RAD_MAX, 70, 1'b0, 1'b0);
    random_phase(3, 65536, 70, 1'b1, 1'b1);
    random_phase(4, $urandom_range(0, 4000), 70, 1'b1, 1'b1);
  endtask

  // receiver stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    settle();
    write_reg(CFG_ACTIVE_DIMS, 4);
    write_reg(CFG_RADIUS, $urandom_range(0, 40000));
    src_idle  = 1'b0;
    snk_idle  = 1'b1;
    hold_sink = 1'b1;
    repeat (90) send_momentum(random_momentum());
    src_idle = 1'b1;
  endtask

  initial begin
    rst        = 1'b1;
    mom.valid  = 1'b0;
    mom.comp_0 = '0;
    mom.comp_1 = '0;
    mom.comp_2 = '0;
    mom.comp_3 = '0;
    cfg.valid  = 1'b0;
    cfg.index  = '0;
    cfg.data   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_unused_components();
    test_dims_saturation();
    test_ignored_index();
    test_radius_extremes();
    test_random_sweep();
    test_backpressure();

    settle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned wait_cycles;
    res.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      wait_cycles = snk_idle ? $urandom_range(0, 7) : 0;
      if (hold_sink) begin
        wait_cycles += HOLD_CYCLES;
        hold_sink = 1'b0;
      end
      if (wait_cycles != 0) begin
        res.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (expected_cut.size() == 0) begin
        report_mismatch("no request outstanding", res.passes_cut, 1'bx);
      end else begin
        want_cut = expected_cut.pop_front();
        if (res.passes_cut !== want_cut) begin
          report_mismatch("wrong value", res.passes_cut, want_cut);
        end
      end
      results_seen++;
    end
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ccmf_pkg.sv
hw/rtl/ccmf_if.sv
hw/rtl/ccmf_cfg.sv
hw/rtl/ccmf_pipe.sv
hw/rtl/cylinder_cut_momentum_filter.sv
sim/testbench.sv
